// ----- hdl/q16a_pkg.sv -----
// Shared types and constants for the Q16.16 fixed-point ALU.
// No dependencies; every module of the block but the checker imports this package.
package q16a_pkg;

    localparam int DataW    = 32;
    localparam int FracW    = 16;
    localparam int NumW     = DataW + FracW;
    // One quotient bit per cell, one cell per dividend bit.
    localparam int DivSteps = NumW;

    localparam logic [1:0] KIND_MUL = 2'd0;
    localparam logic [1:0] KIND_DIV = 2'd1;
    localparam logic [1:0] KIND_MOD = 2'd2;

    localparam logic [DataW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SAT_NEG = 32'h8000_0000;

    // One request in flight through the divider chain.
    typedef struct packed {
        logic             vld;
        logic [1:0]       kind;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic             neg;
        logic             zero;
        logic [NumW-1:0]  num;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dsr;
        logic [DataW-1:0] quot;
        logic [DataW-1:0] mul;
    } item_t;

endpackage

// ----- hdl/q16a_front.sv -----
// Entry stage: registers a request, forms the multiply result and the
// divider magnitudes. Depends on q16a_pkg.
module q16a_front
    import q16a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [1:0]       kind,
    input  logic [DataW-1:0] operand_a,
    input  logic [DataW-1:0] operand_b,
    output item_t            item
);

    item_t            item_reg;
    item_t            item_next;
    logic [2*DataW-1:0] prod;
    logic [DataW-1:0] a_mag;
    logic [DataW-1:0] b_mag;

    // Full signed product and operand magnitudes.
    always_comb
    begin
        prod  = (2*DataW)'($signed(operand_a)) * (2*DataW)'($signed(operand_b));
        a_mag = operand_a[DataW-1] ? (~operand_a + 1'b1) : operand_a;
        b_mag = operand_b[DataW-1] ? (~operand_b + 1'b1) : operand_b;
        item_next      = '0;
        item_next.vld  = in_vld;
        item_next.kind = kind;
        item_next.a    = operand_a;
        item_next.b    = operand_b;
        item_next.neg  = operand_a[DataW-1] ^ operand_b[DataW-1];
        item_next.zero = (operand_b == '0) && (kind == KIND_DIV || kind == KIND_MOD);
        item_next.num  = {a_mag, {FracW{1'b0}}};
        item_next.rem  = '0;
        item_next.dsr  = b_mag;
        item_next.quot = '0;
        item_next.mul  = prod[DataW+FracW-1:FracW];
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg.vld <= 1'b0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

// ----- hdl/q16a_cell.sv -----
// One restoring-division cell: brings in one dividend bit and yields one
// quotient bit, then hands the request to the next cell. Depends on q16a_pkg.
module q16a_cell
    import q16a_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  item_t in_item,
    output item_t out_item
);

    item_t          item_reg;
    item_t          item_next;
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    logic           ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {in_item.rem, in_item.num[NumW-1]};
        diff  = trial - {1'b0, in_item.dsr};
        ge    = (trial >= {1'b0, in_item.dsr});
        item_next      = in_item;
        item_next.rem  = ge ? diff[DataW-1:0] : trial[DataW-1:0];
        item_next.num  = {in_item.num[NumW-2:0], 1'b0};
        item_next.quot = {in_item.quot[DataW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg.vld <= 1'b0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

// ----- hdl/q16a_tail.sv -----
// Result stages: quotient sign and saturation, the modulo product and the
// output register. Depends on q16a_pkg.
module q16a_tail
    import q16a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  item_t            in_item,
    output logic             out_vld,
    output logic [DataW-1:0] result_value,
    output logic             divide_by_zero
);

    logic               s1_vld_reg;
    logic [1:0]         s1_kind_reg;
    logic [DataW-1:0]   s1_a_reg;
    logic [DataW-1:0]   s1_b_reg;
    logic [DataW-1:0]   s1_mul_reg;
    logic [DataW-1:0]   s1_q_reg;
    logic               s1_zero_reg;
    logic [DataW-1:0]   q_next;

    logic               s2_vld_reg;
    logic [1:0]         s2_kind_reg;
    logic [DataW-1:0]   s2_a_reg;
    logic [DataW-1:0]   s2_mul_reg;
    logic [DataW-1:0]   s2_q_reg;
    logic [DataW-1:0]   s2_prod_reg;
    logic               s2_zero_reg;
    logic [DataW-1:0]   prod_next;

    logic               out_vld_reg;
    logic [DataW-1:0]   res_reg;
    logic [DataW-1:0]   res_next;
    logic               dbz_reg;

    // Signed quotient, saturated by the sign of a on a zero divisor.
    always_comb
    begin
        if (in_item.zero)
        begin
            q_next = in_item.a[DataW-1] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            q_next = in_item.neg ? (~in_item.quot + 1'b1) : in_item.quot;
        end
    end

    // Integer part of the quotient times b gives the modulo product; only
    // the low word is needed.
    always_comb
    begin
        prod_next = DataW'($signed(s1_q_reg[DataW-1:FracW])) * $signed(s1_b_reg);
    end

    // Pick the result by operation.
    always_comb
    begin
        case (s2_kind_reg)
            KIND_MUL: res_next = s2_mul_reg;
            KIND_DIV: res_next = s2_q_reg;
            KIND_MOD: res_next = s2_a_reg - s2_prod_reg;
            default:  res_next = '0;
        endcase
    end

    // Control bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_item.vld;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg <= in_item.kind;
            s1_a_reg    <= in_item.a;
            s1_b_reg    <= in_item.b;
            s1_mul_reg  <= in_item.mul;
            s1_q_reg    <= q_next;
            s1_zero_reg <= in_item.zero;
            s2_kind_reg <= s1_kind_reg;
            s2_a_reg    <= s1_a_reg;
            s2_mul_reg  <= s1_mul_reg;
            s2_q_reg    <= s1_q_reg;
            s2_prod_reg <= prod_next;
            s2_zero_reg <= s1_zero_reg;
            res_reg     <= res_next;
            dbz_reg     <= s2_zero_reg;
        end
    end

    assign out_vld        = out_vld_reg;
    assign result_value   = res_reg;
    assign divide_by_zero = dbz_reg;

endmodule

// ----- hdl/q16_16_fixed_point_alu.sv -----
// Q16.16 ALU: multiply, divide and modulo; one request accepted every
// cycle while the output drains. A request passes through one entry stage,
// the 48-cell restoring divider chain, one quotient bit per cell, and
// three result stages.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset (rst_n low, asynchronous) empties the pipeline at once.
module q16_16_fixed_point_alu
    import q16a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  logic [1:0]  s_tuser,  // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] result_value
    output logic [0:0]  m_tuser   // [0] divide_by_zero
);

    logic  en;
    item_t chain [DivSteps+1];

    // All stages move when the output register is free or being taken.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    q16a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (s_tvalid),
        .kind      (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .item      (chain[0])
    );

    // Divider chain, one cell per quotient bit.
    for (genvar g = 0; g < DivSteps; g++)
    begin : g_cell
        q16a_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_item  (chain[g]),
            .out_item (chain[g+1])
        );
    end

    q16a_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_item        (chain[DivSteps]),
        .out_vld        (m_tvalid),
        .result_value   (m_tdata),
        .divide_by_zero (m_tuser[0])
    );

endmodule

// ----- hdl/q16a_checker.sv -----
// Port-level checks for the Q16.16 ALU, bound to the top level.
// Depends only on the top level's ports.
module q16a_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // The input side is ready exactly when the output can move.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // Reset leaves no result pending from the next edge on.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result pending during reset");

    // A result held by the sink keeps its value and flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A stalled output means the input takes nothing.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("request accepted while the pipeline is stalled");

endmodule

bind q16_16_fixed_point_alu q16a_checker u_q16a_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
